// ===== hdl/tfag_pkg.sv =====
// Shared types and constants for the tensor flip address generator.
package tfag_pkg;

  localparam int DIM_W  = 16;
  localparam int WORD_W = 64;
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int NDIM   = 4;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    REG_ROWS         = 3'd0,
    REG_COLUMNS      = 3'd1,
    REG_SLICES       = 3'd2,
    REG_HYPERSLICES  = 3'd3,
    REG_COLUMN_MAJOR = 3'd4,
    REG_FLIP_DIM     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    dim_t       rows;
    dim_t       columns;
    dim_t       slices;
    dim_t       hyperslices;
    logic       column_major;
    logic [1:0] flip_dim;
  } cfg_t;

  // Operands of the three chained multiply-add steps, in evaluation order.
  typedef struct packed {
    dim_t x;
    dim_t a1;
    dim_t m1;
    dim_t a2;
    dim_t m2;
    dim_t a3;
    dim_t m3;
    logic last;
  } terms_t;

endpackage

// ===== hdl/tfag_regs.sv =====
// Configuration register file behind the APB-style port.
module tfag_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tfag_pkg::APB_AW-1:0] paddr,
  input  logic [tfag_pkg::APB_DW-1:0] pwdata,
  output logic [tfag_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output tfag_pkg::cfg_t              cfg
);

  tfag_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = tfag_pkg::reg_idx_t'(paddr[tfag_pkg::APB_AW-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows         <= 16'd1;
      cfg.columns      <= 16'd1;
      cfg.slices       <= 16'd1;
      cfg.hyperslices  <= 16'd1;
      cfg.column_major <= 1'b1;
      cfg.flip_dim     <= 2'd0;
    end else if (wr_en) begin
      case (idx)
        tfag_pkg::REG_ROWS:         cfg.rows         <= pwdata[tfag_pkg::DIM_W-1:0];
        tfag_pkg::REG_COLUMNS:      cfg.columns      <= pwdata[tfag_pkg::DIM_W-1:0];
        tfag_pkg::REG_SLICES:       cfg.slices       <= pwdata[tfag_pkg::DIM_W-1:0];
        tfag_pkg::REG_HYPERSLICES:  cfg.hyperslices  <= pwdata[tfag_pkg::DIM_W-1:0];
        tfag_pkg::REG_COLUMN_MAJOR: cfg.column_major <= pwdata[0];
        tfag_pkg::REG_FLIP_DIM:     cfg.flip_dim     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      tfag_pkg::REG_ROWS:         prdata = tfag_pkg::APB_DW'(cfg.rows);
      tfag_pkg::REG_COLUMNS:      prdata = tfag_pkg::APB_DW'(cfg.columns);
      tfag_pkg::REG_SLICES:       prdata = tfag_pkg::APB_DW'(cfg.slices);
      tfag_pkg::REG_HYPERSLICES:  prdata = tfag_pkg::APB_DW'(cfg.hyperslices);
      tfag_pkg::REG_COLUMN_MAJOR: prdata = tfag_pkg::APB_DW'(cfg.column_major);
      tfag_pkg::REG_FLIP_DIM:     prdata = tfag_pkg::APB_DW'(cfg.flip_dim);
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== hdl/tfag_walk.sv =====
// Coordinate counters, mirrored coordinate, last flag and operand selection.
module tfag_walk (
  input  logic             clk,
  input  logic             rst,
  input  tfag_pkg::cfg_t   cfg,
  input  logic             accept,
  output tfag_pkg::terms_t terms
);

  tfag_pkg::dim_t coord      [tfag_pkg::NDIM];
  tfag_pkg::dim_t coord_next [tfag_pkg::NDIM];
  tfag_pkg::dim_t size_v     [tfag_pkg::NDIM];
  tfag_pkg::dim_t final_v    [tfag_pkg::NDIM];
  tfag_pkg::dim_t c_use      [tfag_pkg::NDIM];
  logic           at_final   [tfag_pkg::NDIM];
  logic           last;

  assign size_v[0] = cfg.rows;
  assign size_v[1] = cfg.columns;
  assign size_v[2] = cfg.slices;
  assign size_v[3] = cfg.hyperslices;

  always_comb begin
    for (int d = 0; d < tfag_pkg::NDIM; d++) begin
      final_v[d]  = (size_v[d] == '0) ? '0 : size_v[d] - 1'b1;
      at_final[d] = (coord[d] == final_v[d]);
      if (cfg.flip_dim == 2'(d)) begin
        c_use[d] = size_v[d] - 1'b1 - coord[d];
      end else begin
        c_use[d] = coord[d];
      end
    end
  end

  assign last = at_final[0] && at_final[1] && at_final[2] && at_final[3];

  // The fastest dimension advances first; a counter at or past its final value
  // wraps to zero and carries into the next one.
  always_comb begin
    logic [1:0] dd;
    logic       carry;
    dd    = '0;
    carry = 1'b1;
    for (int d = 0; d < tfag_pkg::NDIM; d++) begin
      coord_next[d] = last ? '0 : coord[d];
    end
    if (!last) begin
      for (int k = 0; k < tfag_pkg::NDIM; k++) begin
        dd = cfg.column_major ? 2'(k) : 2'(3 - k);
        if (carry) begin
          if (coord[dd] >= final_v[dd]) begin
            coord_next[dd] = '0;
          end else begin
            coord_next[dd] = coord[dd] + 1'b1;
            carry          = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < tfag_pkg::NDIM; d++) begin
        coord[d] <= '0;
      end
    end else if (accept) begin
      for (int d = 0; d < tfag_pkg::NDIM; d++) begin
        coord[d] <= coord_next[d];
      end
    end
  end

  always_comb begin
    terms.last = last;
    if (cfg.column_major) begin
      terms.x  = c_use[3];
      terms.a1 = c_use[2];
      terms.m1 = cfg.slices;
      terms.a2 = c_use[1];
      terms.m2 = cfg.columns;
      terms.a3 = c_use[0];
      terms.m3 = cfg.rows;
    end else begin
      terms.x  = c_use[0];
      terms.a1 = c_use[1];
      terms.m1 = cfg.columns;
      terms.a2 = c_use[2];
      terms.m2 = cfg.slices;
      terms.a3 = c_use[3];
      terms.m3 = cfg.hyperslices;
    end
  end

endmodule

// ===== hdl/tfag_index.sv =====
// Pipeline of three registered multiply-add steps for the index, with payload.
module tfag_index (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             load,
  input  tfag_pkg::terms_t terms,
  input  tfag_pkg::word_t  word_a,
  input  tfag_pkg::word_t  word_b,
  output logic             valid,
  output tfag_pkg::dim_t   dest_index,
  output tfag_pkg::word_t  out_a,
  output tfag_pkg::word_t  out_b,
  output logic             last
);

  tfag_pkg::terms_t s1;
  tfag_pkg::word_t  s1_a, s1_b;
  logic             s1_valid;

  tfag_pkg::dim_t   s2_t, s2_a2, s2_m2, s2_a3, s2_m3;
  tfag_pkg::word_t  s2_a, s2_b;
  logic             s2_last, s2_valid;

  tfag_pkg::dim_t   s3_t, s3_a3, s3_m3;
  tfag_pkg::word_t  s3_a, s3_b;
  logic             s3_last, s3_valid;

  logic [2*tfag_pkg::DIM_W-1:0] p1, p2, p3;

  assign p1 = s1.m1 * s1.x;
  assign p2 = s2_m2 * s2_t;
  assign p3 = s3_m3 * s3_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      valid    <= 1'b0;
    end else if (advance) begin
      s1_valid <= load;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      valid    <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1   <= terms;
      s1_a <= word_a;
      s1_b <= word_b;

      s2_t    <= s1.a1 + p1[tfag_pkg::DIM_W-1:0];
      s2_a2   <= s1.a2;
      s2_m2   <= s1.m2;
      s2_a3   <= s1.a3;
      s2_m3   <= s1.m3;
      s2_last <= s1.last;
      s2_a    <= s1_a;
      s2_b    <= s1_b;

      s3_t    <= s2_a2 + p2[tfag_pkg::DIM_W-1:0];
      s3_a3   <= s2_a3;
      s3_m3   <= s2_m3;
      s3_last <= s2_last;
      s3_a    <= s2_a;
      s3_b    <= s2_b;

      dest_index <= s3_a3 + p3[tfag_pkg::DIM_W-1:0];
      last       <= s3_last;
      out_a      <= s3_a;
      out_b      <= s3_b;
    end
  end

endmodule

// ===== hdl/tensor_flip_address_generator_top.sv =====
// A word accepted at the input is registered into s1 and then passes through the
// chain of three 16-bit multiply-add stages, s1 to s3, into the output registers.
// Throughput: one word per cycle; the whole pipeline holds while a valid output
// word is stalled. Synchronous reset zeroes the coordinate counters, empties the
// pipeline and loads the default configuration.
module tensor_flip_address_generator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tfag_pkg::APB_AW-1:0] paddr,
  input  logic [tfag_pkg::APB_DW-1:0] pwdata,
  output logic [tfag_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [63:0]                 word_a,
  input  logic [63:0]                 word_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 dest_index,
  output logic [63:0]                 out_a,
  output logic [63:0]                 out_b,
  output logic                        last
);

  tfag_pkg::cfg_t   cfg;
  tfag_pkg::terms_t terms;
  logic             advance;
  logic             accept;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  tfag_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfag_walk u_walk (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .terms  (terms)
  );

  tfag_index u_index (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .load       (accept),
    .terms      (terms),
    .word_a     (word_a),
    .word_b     (word_b),
    .valid      (out_valid),
    .dest_index (dest_index),
    .out_a      (out_a),
    .out_b      (out_b),
    .last       (last)
  );

endmodule

// ===== hdl/tfag_checker.sv =====
// Port-level checks for the tensor flip address generator, bound to the top level.
module tfag_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] dest_index,
  input logic [63:0] out_a,
  input logic [63:0] out_b,
  input logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(dest_index) && $stable(out_a) &&
                               $stable(out_b) && $stable(last))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output word");

endmodule

bind tensor_flip_address_generator_top tfag_checker u_tfag_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .dest_index (dest_index),
  .out_a      (out_a),
  .out_b      (out_b),
  .last       (last)
);
